/* rtl/core/lpf_pkg.sv */
// ----------------------------------------------------------------------------
// lpf_pkg: shared constants and types of the ladder low-pass filter
// Widths, fixed-point coefficients and the bundles that pass between the
// sequencer, the serial divider and the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

	// sample and ladder state widths
	localparam int SAMPLE_BITS = 24;
	localparam int STATE_BITS  = 32;

	// coefficient format: unsigned Q.28 held in 30 bits
	localparam int CF     = 28;
	localparam int COEF_W = 30;

	// shared multiplier: signed operand, unsigned coefficient, rounded result
	localparam int A_W   = (STATE_BITS > COEF_W) ? STATE_BITS : COEF_W;
	localparam int P_W   = A_W + COEF_W;
	localparam int R_W   = A_W + 3;
	localparam int ACC_W = A_W + 4;
	localparam int FB_SH = 16;

	// configuration registers
	localparam int CUT_W      = 17;
	localparam int RATE_W     = 18;
	localparam int RES_W      = 17;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CUT_W-1:0]  CUT_RST  = CUT_W'(1000);
	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(44100);
	localparam logic [RES_W-1:0]  RES_RST  = RES_W'(13107);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUTOFF = 2'd0,
		REG_RATE   = 2'd1,
		REG_RES    = 2'd2
	} cfg_reg_t;

	// normalized cutoff division
	localparam int DVD_W     = CUT_W + CF;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam logic [DVD_W-1:0] FC_MIN = DVD_W'(268435);
	localparam logic [DVD_W-1:0] FC_MAX = DVD_W'(131533373);

	// Q.28 constants
	localparam logic [COEF_W-1:0] ONE_Q    = COEF_W'(64'd1 << CF);
	localparam logic [COEF_W-1:0] K_116    = COEF_W'(311385129);
	localparam logic [COEF_W-1:0] K_015    = COEF_W'(40265318);
	localparam logic [COEF_W-1:0] K_035013 = COEF_W'(93987306);
	localparam logic [COEF_W-1:0] K_03     = COEF_W'(80530637);

	// saturation limits on the accumulator scale
	localparam logic signed [ACC_W-1:0] ST_MAX =
		ACC_W'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] ST_MIN =
		ACC_W'(-(64'sd1 <<< (STATE_BITS - 1)));
	localparam logic signed [STATE_BITS-1:0] LIM4  = STATE_BITS'(64'sd1 <<< (STATE_BITS - 2));
	localparam logic signed [STATE_BITS-1:0] NLIM4 = STATE_BITS'(-(64'sd1 <<< (STATE_BITS - 2)));

	typedef struct packed {
		logic                     vld;
		logic signed [A_W-1:0]    a;
		logic        [COEF_W-1:0] c;
		logic                     sh16;
	} mul_req_t;

	typedef struct packed {
		logic                  vld;
		logic signed [R_W-1:0] r;
	} mul_rsp_t;

	typedef struct packed {
		logic              done;
		logic [COEF_W-1:0] fc;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/lpf_if.sv */
// ----------------------------------------------------------------------------
// lpf_if: stream and configuration channels of the ladder low-pass filter
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lpf_pkg::SAMPLE_BITS-1:0] in_sample;
	logic                                   block_end;

	modport source (output valid, in_sample, block_end, input ready);
	modport sink (input valid, in_sample, block_end, output ready);
endinterface

interface lpf_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lpf_pkg::SAMPLE_BITS-1:0] out_sample;
	logic                                   was_clamped;
	logic                                   block_end_out;

	modport source (output valid, out_sample, was_clamped, block_end_out, input ready);
	modport sink (input valid, out_sample, was_clamped, block_end_out, output ready);
endinterface

interface lpf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lpf_pkg::CFG_IDX_W-1:0]      index;
	logic [lpf_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ladder_lowpass_filter.sv */
// ----------------------------------------------------------------------------
// ladder_lowpass_filter: four-pole resonant low-pass ladder filter
// Sequencer, coefficient and ladder registers around one shared multiplier.
// ----------------------------------------------------------------------------
// A sample, once accepted, runs through ten dependent coefficient products
// one after another through the shared two-stage multiplier. It then loads
// the output register, waiting while that register still holds an undrained
// sample, and returns to idle, where the next sample can be taken.
// After reset and after every configuration write the block works out its
// coefficients (a serial cutoff division, then six multiplies) and accepts
// neither samples nor writes meanwhile. A finished sample waits in the
// output register, so the next sample can be taken before it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module ladder_lowpass_filter (
	input wire           clk,
	input wire           arst_n,
	lpf_cfg_if.sink      cfg,
	lpf_in_if.sink       in_ch,
	lpf_out_if.source    out_ch
);

	localparam int SB  = lpf_pkg::SAMPLE_BITS;
	localparam int STB = lpf_pkg::STATE_BITS;
	localparam int AW  = lpf_pkg::A_W;
	localparam int CW  = lpf_pkg::COEF_W;
	localparam int ACW = lpf_pkg::ACC_W;

	// sample/state scaling
	localparam int CW_EXT = SB + STB;
	localparam int D      = STB - SB;
	localparam int SH_UP  = (D > 0) ? D : 0;
	localparam int SH_DN  = (D < 0) ? -D : 0;
	localparam int OH_SH  = (SH_UP > 0) ? SH_UP - 1 : 0;
	localparam logic signed [CW_EXT-1:0] OHALF =
		(SH_UP > 0) ? CW_EXT'(64'sd1 <<< OH_SH) : '0;

	typedef enum logic [4:0] {
		ST_DIV  = 5'b00001,
		ST_DRV  = 5'b00010,
		ST_IDLE = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		DS_F, DS_F2, DS_T, DS_FB, DS_F4, DS_GAIN
	} drv_step_t;

	typedef enum logic [3:0] {
		RS_FB, RS_GAIN, RS_B0, RS_B1, RS_B1F, RS_B2, RS_B2F, RS_B3, RS_B3F, RS_B4
	} run_step_t;

	state_t     st_q;
	drv_step_t  ds_q;
	run_step_t  rs_q;
	logic       busy_q;
	logic       div_go_q;

	logic [lpf_pkg::CUT_W-1:0]  cut_q;
	logic [lpf_pkg::RATE_W-1:0] rate_q;
	logic [lpf_pkg::RES_W-1:0]  res_q;

	logic [CW-1:0] f_q;
	logic [CW-1:0] fb_q;
	logic [CW-1:0] gain_q;
	logic [CW-1:0] f2_q;
	logic [CW-1:0] t_q;
	logic [CW-1:0] omf;

	logic signed [ACW-1:0] acc_q;
	logic signed [STB-1:0] tmp_q;
	logic signed [STB-1:0] stg_q [5];
	logic                  clamp_q;
	logic                  be_q;

	logic                  out_vld_q;
	logic signed [SB-1:0]  out_smp_q;
	logic                  out_clmp_q;
	logic                  out_be_q;

	lpf_pkg::mul_req_t mreq;
	lpf_pkg::mul_rsp_t mrsp;
	lpf_pkg::div_rsp_t drsp;

	logic                   cfg_acc;
	logic                   in_acc;
	logic                   out_free;
	logic signed [CW_EXT-1:0] v_ext;
	logic signed [CW_EXT-1:0] o_ext;
	logic signed [ACW-1:0]  r_ext;
	logic signed [ACW-1:0]  sum;
	logic signed [STB-1:0]  sum_sat;
	logic signed [STB-1:0]  b4_lim;
	logic                   b4_clmp;
	logic [CW-1:0]          rc;

	function automatic logic signed [STB-1:0] sat_st(input logic signed [ACW-1:0] x);
		logic signed [ACW-1:0] y;
		if (x > lpf_pkg::ST_MAX) begin
			y = lpf_pkg::ST_MAX;
		end else if (x < lpf_pkg::ST_MIN) begin
			y = lpf_pkg::ST_MIN;
		end else begin
			y = x;
		end
		return STB'(y);
	endfunction

	lpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.cutoff (cut_q),
		.rate   (rate_q),
		.rsp    (drsp)
	);

	lpf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign cfg.ready    = (st_q == ST_IDLE);
	assign in_ch.ready  = (st_q == ST_IDLE) && !cfg.valid;
	assign cfg_acc      = cfg.valid && cfg.ready;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_free     = !out_vld_q || out_ch.ready;

	assign out_ch.valid         = out_vld_q;
	assign out_ch.out_sample    = out_smp_q;
	assign out_ch.was_clamped   = out_clmp_q;
	assign out_ch.block_end_out = out_be_q;

	assign omf = lpf_pkg::ONE_Q - f_q;
	assign rc  = mrsp.r[CW-1:0];

	// operand select for the shared multiplier
	always_comb begin
		mreq      = '0;
		mreq.vld  = ((st_q == ST_DRV) || (st_q == ST_RUN)) && !busy_q;
		if (st_q == ST_DRV) begin
			case (ds_q)
				DS_F: begin
					mreq.a = AW'(f_q);
					mreq.c = lpf_pkg::K_116;
				end
				DS_F2: begin
					mreq.a = AW'(f_q);
					mreq.c = f_q;
				end
				DS_T: begin
					mreq.a = AW'(f2_q);
					mreq.c = lpf_pkg::K_015;
				end
				DS_FB: begin
					mreq.a    = AW'(res_q);
					mreq.c    = t_q;
					mreq.sh16 = 1'b1;
				end
				DS_F4: begin
					mreq.a = AW'(f2_q);
					mreq.c = f2_q;
				end
				DS_GAIN: begin
					mreq.a = AW'(t_q);
					mreq.c = lpf_pkg::K_035013;
				end
				default: begin
					mreq.a = '0;
					mreq.c = '0;
				end
			endcase
		end else begin
			case (rs_q)
				RS_FB: begin
					mreq.a = AW'(stg_q[4]);
					mreq.c = fb_q;
				end
				RS_GAIN: begin
					mreq.a = AW'(tmp_q);
					mreq.c = gain_q;
				end
				RS_B0: begin
					mreq.a = AW'(stg_q[0]);
					mreq.c = lpf_pkg::K_03;
				end
				RS_B1: begin
					mreq.a = AW'(stg_q[1]);
					mreq.c = omf;
				end
				RS_B1F: begin
					mreq.a = AW'(stg_q[1]);
					mreq.c = lpf_pkg::K_03;
				end
				RS_B2: begin
					mreq.a = AW'(stg_q[2]);
					mreq.c = omf;
				end
				RS_B2F: begin
					mreq.a = AW'(stg_q[2]);
					mreq.c = lpf_pkg::K_03;
				end
				RS_B3: begin
					mreq.a = AW'(stg_q[3]);
					mreq.c = omf;
				end
				RS_B3F: begin
					mreq.a = AW'(stg_q[3]);
					mreq.c = lpf_pkg::K_03;
				end
				RS_B4: begin
					mreq.a = AW'(stg_q[4]);
					mreq.c = omf;
				end
				default: begin
					mreq.a = '0;
					mreq.c = '0;
				end
			endcase
		end
	end

	// accumulate, saturate and clamp
	always_comb begin
		r_ext   = ACW'(mrsp.r);
		sum     = (rs_q == RS_FB) ? (acc_q - r_ext) : (acc_q + r_ext);
		sum_sat = sat_st(sum);
		b4_clmp = 1'b0;
		if (sum_sat > lpf_pkg::LIM4) begin
			b4_lim  = lpf_pkg::LIM4;
			b4_clmp = 1'b1;
		end else if (sum_sat < lpf_pkg::NLIM4) begin
			b4_lim  = lpf_pkg::NLIM4;
			b4_clmp = 1'b1;
		end else begin
			b4_lim = sum_sat;
		end
	end

	// sample in: shift up exactly or down toward minus infinity;
	// sample out: shift down rounding ties up
	always_comb begin
		v_ext = (CW_EXT'(in_ch.in_sample) <<< SH_UP) >>> SH_DN;
		o_ext = ((CW_EXT'(stg_q[4]) + OHALF) <<< SH_DN) >>> SH_UP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_DIV;
			ds_q      <= DS_F;
			rs_q      <= RS_FB;
			busy_q    <= 1'b0;
			div_go_q  <= 1'b1;
			cut_q     <= lpf_pkg::CUT_RST;
			rate_q    <= lpf_pkg::RATE_RST;
			res_q     <= lpf_pkg::RES_RST;
			out_vld_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				stg_q[i] <= '0;
			end
		end else begin
			div_go_q <= 1'b0;
			if (mreq.vld) begin
				busy_q <= 1'b1;
			end else if (mrsp.vld) begin
				busy_q <= 1'b0;
			end
			// load a finished sample, or drop the one that was just taken
			if ((st_q == ST_DONE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_DIV: begin
					if (drsp.done) begin
						ds_q <= DS_F;
						st_q <= ST_DRV;
					end
				end
				ST_DRV: begin
					if (mrsp.vld) begin
						if (ds_q == DS_GAIN) begin
							st_q <= ST_IDLE;
						end else begin
							ds_q <= drv_step_t'(ds_q + 3'd1);
						end
					end
				end
				ST_IDLE: begin
					if (cfg_acc) begin
						case (lpf_pkg::cfg_reg_t'(cfg.index))
							lpf_pkg::REG_CUTOFF: cut_q  <= cfg.data[lpf_pkg::CUT_W-1:0];
							lpf_pkg::REG_RATE:   rate_q <= cfg.data[lpf_pkg::RATE_W-1:0];
							lpf_pkg::REG_RES:    res_q  <= cfg.data[lpf_pkg::RES_W-1:0];
							default: ;
						endcase
						div_go_q <= 1'b1;
						st_q     <= ST_DIV;
					end else if (in_acc) begin
						rs_q <= RS_FB;
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (mrsp.vld) begin
						case (rs_q)
							RS_B1: begin
								stg_q[1] <= sum_sat;
								stg_q[0] <= tmp_q;
							end
							RS_B2: stg_q[2] <= sum_sat;
							RS_B3: stg_q[3] <= sum_sat;
							RS_B4: stg_q[4] <= b4_lim;
							default: ;
						endcase
						if (rs_q == RS_B4) begin
							st_q <= ST_DONE;
						end else begin
							rs_q <= run_step_t'(rs_q + 4'd1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((st_q == ST_DIV) && drsp.done) begin
			f_q <= drsp.fc;
		end
		if ((st_q == ST_DRV) && mrsp.vld) begin
			case (ds_q)
				DS_F:    f_q    <= rc;
				DS_F2:   f2_q   <= rc;
				DS_T:    t_q    <= lpf_pkg::ONE_Q - rc;
				DS_FB:   fb_q   <= rc;
				DS_F4:   t_q    <= rc;
				DS_GAIN: gain_q <= rc;
				default: ;
			endcase
		end
		if (in_acc) begin
			acc_q <= ACW'(v_ext);
			be_q  <= in_ch.block_end;
		end
		if ((st_q == ST_RUN) && mrsp.vld) begin
			case (rs_q)
				RS_FB: tmp_q <= sum_sat;
				RS_GAIN: begin
					// hold the unsaturated product, keep its saturated copy for b0
					acc_q <= r_ext;
					tmp_q <= sat_st(r_ext);
				end
				RS_B0, RS_B1F, RS_B2F, RS_B3F: acc_q <= sum;
				RS_B1, RS_B2, RS_B3: acc_q <= ACW'(sum_sat);
				RS_B4: clamp_q <= b4_clmp;
				default: ;
			endcase
		end
		if ((st_q == ST_DONE) && out_free) begin
			out_smp_q  <= SB'(o_ext);
			out_clmp_q <= clamp_q;
			out_be_q   <= be_q;
		end
	end

	a_rsp_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.vld |-> busy_q)
		else $error("multiplier result with no operation in flight");

	a_b4_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stg_q[4] <= lpf_pkg::LIM4) && (stg_q[4] >= lpf_pkg::NLIM4))
		else $error("last ladder stage outside +-4.0");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(st_q == ST_DONE))
		else $error("output transaction raised outside completion");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !busy_q)
		else $error("multiplier busy while idle");

endmodule

`default_nettype wire

/* rtl/core/lpf_div.sv */
// ----------------------------------------------------------------------------
// lpf_div: serial divider for the normalized cutoff
// Restoring division of cutoff << 28 by the sample rate, one quotient bit
// per cycle, with the result clamped to the allowed cutoff range.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           go,
	input  wire [lpf_pkg::CUT_W-1:0]      cutoff,
	input  wire [lpf_pkg::RATE_W-1:0]     rate,
	output lpf_pkg::div_rsp_t             rsp
);

	localparam logic [lpf_pkg::DIV_CNT_W-1:0] LAST_BIT =
		lpf_pkg::DIV_CNT_W'(lpf_pkg::DVD_W - 1);

	logic                             busy_q;
	logic                             done_q;
	logic [lpf_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [lpf_pkg::DVD_W-1:0]        dvd_q;
	logic [lpf_pkg::RATE_W-1:0]       rem_q;
	logic [lpf_pkg::RATE_W:0]         cand;
	logic [lpf_pkg::RATE_W:0]         diff;
	logic                             ge;
	logic [lpf_pkg::DVD_W-1:0]        fc_clamped;

	always_comb begin
		cand = {rem_q, dvd_q[lpf_pkg::DVD_W-1]};
		ge   = (cand >= {1'b0, rate});
		diff = cand - {1'b0, rate};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + lpf_pkg::DIV_CNT_W'(1);
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= {cutoff, {lpf_pkg::CF{1'b0}}};
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lpf_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[lpf_pkg::RATE_W-1:0] : cand[lpf_pkg::RATE_W-1:0];
		end
	end

	always_comb begin
		if (dvd_q > lpf_pkg::FC_MAX) begin
			fc_clamped = lpf_pkg::FC_MAX;
		end else if (dvd_q < lpf_pkg::FC_MIN) begin
			fc_clamped = lpf_pkg::FC_MIN;
		end else begin
			fc_clamped = dvd_q;
		end
		rsp.done = done_q;
		rsp.fc   = fc_clamped[lpf_pkg::COEF_W-1:0];
	end

endmodule

`default_nettype wire

/* rtl/core/lpf_mul.sv */
// ----------------------------------------------------------------------------
// lpf_mul: shared coefficient multiplier
// Two stages: magnitude times coefficient, then round to nearest (ties away
// from zero) at Q.28 or Q.16 and restore the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_mul (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire lpf_pkg::mul_req_t req,
	output lpf_pkg::mul_rsp_t      rsp
);

	localparam int PW = lpf_pkg::P_W;
	localparam int RW = lpf_pkg::R_W;
	localparam logic [PW:0] HALF_HI = (PW + 1)'(1) << (lpf_pkg::CF - 1);
	localparam logic [PW:0] HALF_LO = (PW + 1)'(1) << (lpf_pkg::FB_SH - 1);

	logic [lpf_pkg::A_W-1:0] mag;
	logic [PW-1:0]           prod;
	logic                    vld_s1;
	logic                    neg_s1;
	logic                    sh_s1;
	logic [PW-1:0]           p_s1;
	logic [PW:0]             rnd;
	logic [PW:0]             shd;
	logic [RW-2:0]           mag_r;
	logic signed [RW-1:0]    r_next;
	logic                    vld_s2;
	logic signed [RW-1:0]    r_s2;

	always_comb begin
		mag  = req.a[lpf_pkg::A_W-1] ? lpf_pkg::A_W'(-req.a) : lpf_pkg::A_W'(req.a);
		prod = PW'(mag) * PW'(req.c);
	end

	always_comb begin
		rnd    = {1'b0, p_s1} + (sh_s1 ? HALF_LO : HALF_HI);
		shd    = sh_s1 ? (rnd >> lpf_pkg::FB_SH) : (rnd >> lpf_pkg::CF);
		mag_r  = shd[RW-2:0];
		r_next = neg_s1 ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= prod;
		neg_s1 <= req.a[lpf_pkg::A_W-1];
		sh_s1  <= req.sh16;
		r_s2   <= r_next;
	end

	assign rsp.vld = vld_s2;
	assign rsp.r   = r_s2;

endmodule

`default_nettype wire
